// ===== sv/stepper_phase_sequencer_homing_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stepper phase sequencer with homing
// Shared forms for concurrent checks, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef STEPPER_PHASE_SEQUENCER_HOMING_DEFINES_SVH
`define STEPPER_PHASE_SEQUENCER_HOMING_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPH_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/sph_pkg.sv =====
// ----------------------------------------------------------------------------
// Stepper phase sequencer package
// Widths, codes, register indexes and types shared by the sequencer files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sph_pkg;

    // Counter width and number of phases in the drive sequence.
    localparam int COUNT_WIDTH = 16;
    localparam int PHASES      = 8;
    localparam int PHASE_W     = (PHASES > 1) ? $clog2(PHASES) : 1;

    // Field and register widths.
    localparam int CMD_W      = 2;
    localparam int STEP_W     = 16;
    localparam int LEVEL_W    = 10;
    localparam int COIL_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [PHASE_W-1:0]     t_phase;

    // Command codes carried by an input transaction.
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_MOVE = 2'd1,
        CMD_HOME = 2'd2
    } t_cmd;

    // Sequencer modes.
    typedef enum logic [2:0] {
        MODE_IDLE         = 3'd0,
        MODE_MOVE         = 3'd1,
        MODE_BACKOFF      = 3'd2,
        MODE_SEARCH_START = 3'd3,
        MODE_SEARCH_CHECK = 3'd4,
        MODE_OFFSET       = 3'd5
    } t_mode;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DELAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_ANLG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_THR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TABLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_TRIES   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_OFFSET  = 3'd6;

    // Register reset values.
    localparam logic [15:0]           RST_STEP_DELAY  = 16'd5;
    localparam logic [LEVEL_W-1:0]    RST_SENSOR_THR  = 10'd300;
    localparam logic [CFG_DATA_W-1:0] RST_PHASE_TABLE = 32'd2563007025;
    localparam logic [15:0]           RST_HOME_TRIES  = 16'd10000;
    localparam logic [15:0]           RST_BACKOFF     = 16'd100;
    localparam logic [15:0]           RST_HOME_OFFSET = 16'd90;

endpackage

`default_nettype wire

// ===== sv/sph_in_if.sv =====
// ----------------------------------------------------------------------------
// Sequencer input channel
// Valid/ready channel carrying one tick or command transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sph_in_if;
    logic                          valid;
    logic                          ready;
    logic [sph_pkg::CMD_W-1:0]     command;
    logic [sph_pkg::STEP_W-1:0]    step_count;
    logic                          direction_fwd;
    logic [sph_pkg::LEVEL_W-1:0]   sensor_level;

    modport source (
        output valid, command, step_count, direction_fwd, sensor_level,
        input  ready
    );
    modport sink (
        input  valid, command, step_count, direction_fwd, sensor_level,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/sph_out_if.sv =====
// ----------------------------------------------------------------------------
// Sequencer result channel
// Valid/ready channel carrying coil pattern and status for each transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sph_out_if;
    logic                         valid;
    logic                         ready;
    logic [sph_pkg::COIL_W-1:0]   coil_drive;
    logic                         busy_res;
    logic                         home_done;
    logic                         home_ok;

    modport source (
        output valid, coil_drive, busy_res, home_done, home_ok,
        input  ready
    );
    modport sink (
        input  valid, coil_drive, busy_res, home_done, home_ok,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/stepper_phase_sequencer_homing.sv =====
// ----------------------------------------------------------------------------
// Stepper phase sequencer with homing
// Steps a four-coil motor through a phase table for move and home commands,
// one input transaction per tick, one result transaction per input.
// ----------------------------------------------------------------------------
//  Channel   | Direction | Handshake     | Contents
//  ----------+-----------+---------------+-----------------------------------
//  i_in      | in        | valid/ready   | command, step count, dir, sensor
//  o_out     | out       | valid/ready   | coil pattern, busy, done, ok
//  i_cfg_*   | in        | write enable  | register index and data
//
//  One transaction per clock unless o_out stalls: the state update and the
//  result are produced by a single pass of logic in the accepting cycle;
//  the result appears on o_out in the next cycle from the output register.
//  Input is accepted whenever the output register is empty or being drained,
//  so a stalled sink holds one result and then stops the input.
//  Reset is synchronous and active low; it clears the sequencer to idle and
//  loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "stepper_phase_sequencer_homing_defines.svh"

module stepper_phase_sequencer_homing (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    sph_in_if.sink                                 i_in,
    sph_out_if.source                              o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [sph_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [sph_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // Configuration registers.
    logic [15:0]                        r_step_delay;
    logic                               r_sensor_analog;
    logic [sph_pkg::LEVEL_W-1:0]        r_sensor_thr;
    logic [sph_pkg::CFG_DATA_W-1:0]     r_phase_table;
    logic [15:0]                        r_home_tries;
    logic [15:0]                        r_backoff;
    logic [15:0]                        r_home_offset;

    // Sequencer state.
    sph_pkg::t_mode                     r_mode,  n_mode;
    sph_pkg::t_phase                    r_phase, n_phase;
    sph_pkg::t_count                    r_steps, n_steps;
    sph_pkg::t_count                    r_delay, n_delay;
    sph_pkg::t_count                    r_tries, n_tries;
    logic                               r_fwd,   n_fwd;

    // Result register.
    logic                               r_out_valid;
    logic [sph_pkg::COIL_W-1:0]         r_coil;
    logic                               r_busy;
    logic                               r_done;
    logic                               r_ok;

    logic                               accept;
    logic                               closed;
    logic                               do_step;
    logic                               step_fwd;
    logic                               done;
    logic                               ok;
    sph_pkg::t_count                    tries_dec;
    sph_pkg::t_phase                    phase_stepped;
    logic [4:0]                         coil_base;
    logic [sph_pkg::COIL_W-1:0]         coil_next;

    // Handshake: take a transaction when the result register can be refilled.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_delay    <= sph_pkg::RST_STEP_DELAY;
            r_sensor_analog <= 1'b0;
            r_sensor_thr    <= sph_pkg::RST_SENSOR_THR;
            r_phase_table   <= sph_pkg::RST_PHASE_TABLE;
            r_home_tries    <= sph_pkg::RST_HOME_TRIES;
            r_backoff       <= sph_pkg::RST_BACKOFF;
            r_home_offset   <= sph_pkg::RST_HOME_OFFSET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sph_pkg::CFG_STEP_DELAY:  r_step_delay    <= i_cfg_data[15:0];
                sph_pkg::CFG_SENSOR_ANLG: r_sensor_analog <= i_cfg_data[0];
                sph_pkg::CFG_SENSOR_THR:  r_sensor_thr    <= i_cfg_data[sph_pkg::LEVEL_W-1:0];
                sph_pkg::CFG_PHASE_TABLE: r_phase_table   <= i_cfg_data;
                sph_pkg::CFG_HOME_TRIES:  r_home_tries    <= i_cfg_data[15:0];
                sph_pkg::CFG_BACKOFF:     r_backoff       <= i_cfg_data[15:0];
                sph_pkg::CFG_HOME_OFFSET: r_home_offset   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Home sensor decision for the sample in this transaction.
    assign closed = r_sensor_analog ? (i_in.sensor_level > r_sensor_thr)
                                    : (i_in.sensor_level != '0);

    assign tries_dec = r_tries - sph_pkg::t_count'(1);

    // Phase index after one step in the requested direction, wrapping both ways.
    always_comb begin
        if (step_fwd) begin
            phase_stepped = (r_phase == sph_pkg::t_phase'(sph_pkg::PHASES - 1))
                          ? '0 : r_phase + sph_pkg::t_phase'(1);
        end else begin
            phase_stepped = (r_phase == '0)
                          ? sph_pkg::t_phase'(sph_pkg::PHASES - 1)
                          : r_phase - sph_pkg::t_phase'(1);
        end
    end

    // Next state and status for the accepted transaction.
    always_comb begin
        n_mode   = r_mode;
        n_phase  = r_phase;
        n_steps  = r_steps;
        n_delay  = r_delay;
        n_tries  = r_tries;
        n_fwd    = r_fwd;
        do_step  = 1'b0;
        step_fwd = 1'b1;
        done     = 1'b0;
        ok       = 1'b0;

        if (accept) begin
            if (r_mode == sph_pkg::MODE_IDLE) begin
                // Start commands only load the state; stepping begins next tick.
                case (sph_pkg::t_cmd'(i_in.command))
                    sph_pkg::CMD_MOVE: begin
                        n_mode  = sph_pkg::MODE_MOVE;
                        n_steps = sph_pkg::t_count'(i_in.step_count);
                        n_fwd   = i_in.direction_fwd;
                        n_delay = '0;
                    end
                    sph_pkg::CMD_HOME: begin
                        n_delay = '0;
                        if (closed) begin
                            n_mode  = sph_pkg::MODE_BACKOFF;
                            n_steps = sph_pkg::t_count'(r_backoff);
                        end else begin
                            n_mode  = sph_pkg::MODE_SEARCH_START;
                            n_tries = sph_pkg::t_count'(r_home_tries);
                        end
                    end
                    default: ;
                endcase
            end else if (r_delay != '0) begin
                // Inter-step wait.
                n_delay = r_delay - sph_pkg::t_count'(1);
            end else begin
                case (r_mode)
                    sph_pkg::MODE_MOVE, sph_pkg::MODE_BACKOFF, sph_pkg::MODE_OFFSET: begin
                        if (r_steps == '0) begin
                            if (r_mode == sph_pkg::MODE_BACKOFF) begin
                                n_mode  = sph_pkg::MODE_SEARCH_START;
                                n_tries = sph_pkg::t_count'(r_home_tries);
                            end else begin
                                if (r_mode == sph_pkg::MODE_OFFSET) begin
                                    done = 1'b1;
                                    ok   = 1'b1;
                                end
                                n_mode = sph_pkg::MODE_IDLE;
                            end
                        end else begin
                            do_step  = 1'b1;
                            step_fwd = (r_mode == sph_pkg::MODE_MOVE) ? r_fwd
                                     : (r_mode == sph_pkg::MODE_OFFSET);
                            n_steps  = r_steps - sph_pkg::t_count'(1);
                        end
                    end
                    sph_pkg::MODE_SEARCH_START: begin
                        if (r_tries == '0) begin
                            n_mode = sph_pkg::MODE_IDLE;
                            done   = 1'b1;
                        end else begin
                            do_step = 1'b1;
                            n_mode  = sph_pkg::MODE_SEARCH_CHECK;
                        end
                    end
                    sph_pkg::MODE_SEARCH_CHECK: begin
                        if (closed) begin
                            n_mode  = sph_pkg::MODE_OFFSET;
                            n_steps = sph_pkg::t_count'(r_home_offset);
                        end else begin
                            n_tries = tries_dec;
                            if (tries_dec == '0) begin
                                n_mode = sph_pkg::MODE_IDLE;
                                done   = 1'b1;
                            end else begin
                                do_step = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_mode = sph_pkg::MODE_IDLE;
                    end
                endcase
            end

            // A step advances the phase and restarts the wait.
            if (do_step) begin
                n_phase = phase_stepped;
                n_delay = sph_pkg::t_count'(r_step_delay);
            end
        end
    end

    // Coil pattern for the phase after this transaction.
    assign coil_base = 5'(n_phase) << 2;
    assign coil_next = r_phase_table[coil_base +: sph_pkg::COIL_W];

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= sph_pkg::MODE_IDLE;
            r_phase <= '0;
            r_steps <= '0;
            r_delay <= '0;
            r_tries <= '0;
            r_fwd   <= 1'b1;
        end else begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_steps <= n_steps;
            r_delay <= n_delay;
            r_tries <= n_tries;
            r_fwd   <= n_fwd;
        end
    end

    // Result register: loaded on each accepted transaction, held while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_coil <= coil_next;
            r_busy <= (n_mode != sph_pkg::MODE_IDLE);
            r_done <= done;
            r_ok   <= ok;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.coil_drive = r_coil;
    assign o_out.busy_res   = r_busy;
    assign o_out.home_done  = r_done;
    assign o_out.home_ok    = r_ok;

    // Checks on the sequencer logic.
    `SPH_ASSERT_NEXT(a_start_leaves_idle,
        accept && r_mode == sph_pkg::MODE_IDLE &&
        (i_in.command == sph_pkg::CMD_MOVE || i_in.command == sph_pkg::CMD_HOME),
        r_mode != sph_pkg::MODE_IDLE, "start command did not leave idle")
    `SPH_ASSERT_NEXT(a_state_holds_without_transaction, !accept,
        $stable(r_mode) && $stable(r_phase) && $stable(r_delay) && $stable(r_steps),
        "sequencer state changed without an input transaction")
    `SPH_ASSERT_NEXT(a_phase_holds_during_wait,
        accept && r_mode != sph_pkg::MODE_IDLE && r_delay != '0,
        r_phase == $past(r_phase), "phase moved during the inter-step wait")
    `SPH_ASSERT_SAME(a_ok_only_when_done, o_out.valid && o_out.home_ok,
        o_out.home_done && !o_out.busy_res, "home success reported without completion")

endmodule

`default_nettype wire
